@@ src/pol_pkg.sv @@
// Shared constants for the positional ordered list block.
package pol_pkg;

    localparam int CAPACITY = 64;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // Stream payload widths: fields packed from bit 0 and padded to whole bytes.
    localparam int S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + LEN_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd3;

endpackage

@@ src/positional_ordered_list.sv @@
// Top level of the positional ordered list: command sequencer around one entry RAM.
//
// Commands arrive on the s_axis channel: tuser carries the opcode (insert, delete,
// dump) and tdata the value and the zero-based position. Results leave on the
// m_axis channel: tuser carries the status, tdata the entry value and the list
// length after the command, and tlast marks the final result of a command.
// Entries sit packed from address 0 in one RAM with a registered read port.
// An insert moves the entries at and behind its position up by one address, a
// delete moves the entries behind its position down by one; reads and writes of
// that move overlap, each entry being written while the next one is read.
// Insert and delete give one transaction. A dump streams one entry per cycle
// while the receiver keeps tready high, reading each entry one address ahead.
// One command is in work at a time: s_axis_tready is high only while idle, but
// the output register lets the next command start while a result waits.
// A stalled receiver holds the result and pauses the dump in place.
// Reset empties the list at once; no clearing pass over the RAM is needed.
module positional_ordered_list #(
    parameter int P_CAPACITY = pol_pkg::CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] value, [38:32] position, upper bits zero
    input  logic [pol_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [pol_pkg::OPCODE_W-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] entry_value, [38:32] list_length, upper bits zero
    output logic [pol_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [pol_pkg::STATUS_W-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int AW = (P_CAPACITY > 1) ? $clog2(P_CAPACITY) : 1;
    localparam int CW = $clog2(P_CAPACITY + 1);
    localparam int VW = pol_pkg::VALUE_W;
    localparam int PW = pol_pkg::POS_W;
    localparam int SW = pol_pkg::STATUS_W;
    localparam int LW = pol_pkg::LEN_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PUT   = 6'b001000,
        S_DUMP  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [pol_pkg::OPCODE_W-1:0] r_op, n_op;
    logic [VW-1:0] r_val, n_val;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic          r_wr_pend, n_wr_pend;
    logic [SW-1:0] r_status, n_status;
    logic [CW-1:0] r_count, n_count;

    logic          r_out_valid;
    logic [VW-1:0] r_out_value;
    logic [SW-1:0] r_out_status;
    logic [CW-1:0] r_out_len;
    logic          r_out_last;

    logic          out_free;
    logic          out_load;
    logic [VW-1:0] out_value;
    logic [SW-1:0] out_status;
    logic          out_last;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [VW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [VW-1:0] ram_rd_data;

    logic [pol_pkg::OPCODE_W-1:0] in_opcode;
    logic [VW-1:0] in_value;
    logic [PW-1:0] in_pos;
    logic [PW-1:0] count_ext;
    logic [PW-1:0] ins_pos;
    logic [PW-1:0] del_pos;
    logic          is_full;
    logic          is_empty;
    logic          last_read;

    assign in_opcode = s_axis_tuser;
    assign in_value  = s_axis_tdata[VW-1:0];
    assign in_pos    = s_axis_tdata[VW+PW-1:VW];

    assign count_ext = PW'(r_count);
    assign is_full   = (r_count == CW'(P_CAPACITY));
    assign is_empty  = (r_count == '0);
    // Positions past the end act on the tail.
    assign ins_pos   = (in_pos > count_ext) ? count_ext : in_pos;
    assign del_pos   = (in_pos > count_ext - PW'(1)) ? count_ext - PW'(1) : in_pos;

    assign last_read = (r_op == pol_pkg::OP_INSERT) ? (r_rd_addr == CW'(r_pos))
                                                    : (r_rd_addr == r_count - CW'(1));

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_pos       = r_pos;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_status    = r_status;
        n_count     = r_count;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_addr[AW-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_addr;
        ram_wr_data = ram_rd_data;
        out_load    = 1'b0;
        out_value   = '0;
        out_status  = r_status;
        out_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op      = in_opcode;
                    n_val     = in_value;
                    n_wr_pend = 1'b0;
                    case (in_opcode)
                        pol_pkg::OP_INSERT: begin
                            if (is_full) begin
                                n_status = pol_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_status = pol_pkg::ST_DONE;
                                n_pos    = AW'(ins_pos);
                                if (ins_pos == count_ext) begin
                                    n_state = S_PUT;
                                end else begin
                                    n_rd_addr = r_count - CW'(1);
                                    n_state   = S_SHIFT;
                                end
                            end
                        end
                        pol_pkg::OP_DELETE: begin
                            if (is_empty) begin
                                n_status = pol_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_status = pol_pkg::ST_DONE;
                                n_pos    = AW'(del_pos);
                                if (del_pos == count_ext - PW'(1)) begin
                                    n_count = r_count - CW'(1);
                                    n_state = S_RESP;
                                end else begin
                                    n_rd_addr = CW'(del_pos) + CW'(1);
                                    n_state   = S_SHIFT;
                                end
                            end
                        end
                        pol_pkg::OP_DUMP: begin
                            if (is_empty) begin
                                n_status = pol_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                n_rd_addr   = CW'(1);
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = pol_pkg::ST_DONE;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Read one entry while the previously read one is written to its
                // neighbor; the two addresses never coincide.
                ram_rd_en = 1'b1;
                ram_wr_en = r_wr_pend;
                n_wr_pend = 1'b1;
                if (r_op == pol_pkg::OP_INSERT) begin
                    n_wr_addr = r_rd_addr[AW-1:0] + AW'(1);
                end else begin
                    n_wr_addr = r_rd_addr[AW-1:0] - AW'(1);
                end
                if (last_read) begin
                    n_state = S_DRAIN;
                end else if (r_op == pol_pkg::OP_INSERT) begin
                    n_rd_addr = r_rd_addr - CW'(1);
                end else begin
                    n_rd_addr = r_rd_addr + CW'(1);
                end
            end
            S_DRAIN: begin
                ram_wr_en = 1'b1;
                n_wr_pend = 1'b0;
                if (r_op == pol_pkg::OP_INSERT) begin
                    n_state = S_PUT;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_pos;
                ram_wr_data = r_val;
                n_count     = r_count + CW'(1);
                n_state     = S_RESP;
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_value  = ram_rd_data;
                    out_status = pol_pkg::ST_ENTRY;
                    out_last   = (r_rd_addr == r_count);
                    if (r_rd_addr == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_rd_en = 1'b1;
                        n_rd_addr = r_rd_addr + CW'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_status  <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The length is taken after the count update of the finishing command.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value  <= out_value;
            r_out_status <= out_status;
            r_out_len    <= r_count;
            r_out_last   <= out_last;
        end
    end

    pol_ram #(
        .P_WIDTH (VW),
        .P_DEPTH (P_CAPACITY)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(pol_pkg::M_TDATA_W - VW - LW)'(0), LW'(r_out_len), r_out_value};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ src/pol_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pol_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 64,
    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [P_WIDTH-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [P_WIDTH-1:0] o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
